[rtl/core/hwe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwe_pkg: shared definitions for the hit window event builder
// Store depth, field widths, command and status codes.
// ----------------------------------------------------------------------------
package hwe_pkg;

    localparam int MAX_HITS  = 4096;
    localparam int ADDR_W    = $clog2(MAX_HITS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int TIME_W    = 48;
    localparam int WIN_W     = 20;
    localparam int THR_W     = 13;
    localparam int LABEL_W   = 13;
    localparam int EVNUM_W   = 12;
    localparam int LMEM_W    = LABEL_W + 1;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_NOT_RUN = 2'd3
    } status_t;

    localparam logic CFG_WINDOW    = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

endpackage

[rtl/core/hwe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwe_ram: single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module hwe_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

[rtl/core/hit_window_event_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hit_window_event_builder: sliding-window multiplicity trigger
// Stores hit timestamps, groups them into events with a sliding window and
// answers per-hit queries for event label and time relative to the event.
// ----------------------------------------------------------------------------
// Flow: the block takes one input transaction at a time and raises in_stall
// until its result transaction has been taken. Load, clear and a read that
// fails its checks are answered from the idle state; a successful read goes
// through a wait state for the registered label and relative-time data. A run
// clears the labels, walks the window with time-store lookups, runs the
// marking sweeps and ends with the relative-time pass. The walk looks every
// hit up once as it enters the window and once as it leaves it, and each
// window step adds a center lookup and two failing edge checks; there is at
// most one step per hit. The run time is set by the single-port time memory,
// where every lookup needs a read state and a wait state, and by the one
// shared 49-bit subtractor that does every time comparison.
// ----------------------------------------------------------------------------
module hit_window_event_builder
    import hwe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           cmd,
    input  logic [TIME_W-1:0]    hit_time,
    input  logic [ADDR_W-1:0]    hit_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic                 assigned,
    output logic [EVNUM_W-1:0]   event_number,
    output logic [TIME_W-1:0]    relative_time,
    output logic [CNT_W-1:0]     events_found,
    output logic [CNT_W-1:0]     hits_assigned,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [WIN_W-1:0]     cfg_data
);

    // The run is a small sequencer. Every "_RD" state puts an address on the
    // memories, and the matching "_WT" state uses the registered read data.
    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_WAIT,
        S_CLR,
        S_T0_RD,
        S_T0_WT,
        S_INIT_RD,
        S_INIT_WT,
        S_INIT_DEC,
        S_IDX_RD,
        S_IDX_WT,
        S_MN_RD,
        S_MN_WT,
        S_MX_RD,
        S_MX_WT,
        S_EVAL,
        S_MARK,
        S_REL_RD,
        S_REL_WT
    } state_t;

    state_t              state_reg, state_next;
    logic [WIN_W-1:0]    window_reg, window_next;
    logic [THR_W-1:0]    thr_reg, thr_next;
    logic [CNT_W-1:0]    hit_total_reg, hit_total_next;
    logic                run_done_reg, run_done_next;
    logic [CNT_W-1:0]    ev_cnt_reg, ev_cnt_next;
    logic [CNT_W-1:0]    asg_tot_reg, asg_tot_next;

    logic [CNT_W-1:0]    ctr_reg, ctr_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    mn_reg, mn_next;
    logic [CNT_W-1:0]    mx_reg, mx_next;
    logic [CNT_W-1:0]    a_reg, a_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [LABEL_W-1:0]  mark_lbl_reg, mark_lbl_next;
    logic [LABEL_W-1:0]  ec_reg, ec_next;
    logic                in_ev_reg, in_ev_next;
    logic [TIME_W-1:0]   t0_reg, t0_next;
    logic [TIME_W-1:0]   tidx_reg, tidx_next;
    logic [TIME_W-1:0]   base_reg, base_next;
    logic [LABEL_W-1:0]  last_reg, last_next;
    logic                have_last_reg, have_last_next;
    logic [CNT_W-1:0]    total_reg, total_next;

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          status_reg, status_next;
    logic                assigned_reg, assigned_next;
    logic [EVNUM_W-1:0]  evn_reg, evn_next;
    logic [TIME_W-1:0]   rel_reg, rel_next;

    // Memory ports
    logic                t_we, l_we, r_we;
    logic [ADDR_W-1:0]   t_addr, l_addr, r_addr;
    logic [TIME_W-1:0]   t_wdata, t_rdata, r_wdata, r_rdata;
    logic [LMEM_W-1:0]   l_wdata, l_rdata;

    // Shared subtract and compare unit
    logic [TIME_W-1:0]   op_a, op_b;
    logic [TIME_W:0]     diff;
    logic                lt_w, gt_w;
    logic                new_base;
    logic [TIME_W-1:0]   base_sel;

    // Evaluation of one window step
    logic [CNT_W-1:0]    mx_dec;
    logic [CNT_W:0]      cnt_lhs, cnt_rhs;
    logic                over;
    logic                accept;

    hwe_ram #(.DEPTH(MAX_HITS), .WIDTH(TIME_W)) u_time_ram (
        .clk   (clk),
        .we    (t_we),
        .addr  (t_addr),
        .wdata (t_wdata),
        .rdata (t_rdata)
    );

    hwe_ram #(.DEPTH(MAX_HITS), .WIDTH(LMEM_W)) u_label_ram (
        .clk   (clk),
        .we    (l_we),
        .addr  (l_addr),
        .wdata (l_wdata),
        .rdata (l_rdata)
    );

    hwe_ram #(.DEPTH(MAX_HITS), .WIDTH(TIME_W)) u_rel_ram (
        .clk   (clk),
        .we    (r_we),
        .addr  (r_addr),
        .wdata (r_wdata),
        .rdata (r_rdata)
    );

    assign in_stall      = (state_reg != S_IDLE) || out_valid_reg;
    assign accept        = in_valid && !in_stall;
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign assigned      = assigned_reg;
    assign event_number  = evn_reg;
    assign relative_time = rel_reg;
    assign events_found  = ev_cnt_reg;
    assign hits_assigned = asg_tot_reg;

    // A new relative-time base starts wherever the label changes in store order.
    assign new_base = !have_last_reg || (last_reg != l_rdata[LABEL_W-1:0]);
    assign base_sel = new_base ? t_rdata : base_reg;

    always_comb
    begin
        op_a = t_rdata;
        op_b = t0_reg;
        unique case (state_reg)
            S_MN_WT:
            begin
                op_a = tidx_reg;
                op_b = t_rdata;
            end
            S_MX_WT:
            begin
                op_b = tidx_reg;
            end
            S_REL_WT:
            begin
                op_b = base_sel;
            end
            default:
            begin
                op_b = t0_reg;
            end
        endcase
    end

    // Time differences are signed, so hits out of order compare correctly.
    assign diff = {1'b0, op_a} - {1'b0, op_b};
    assign lt_w = $signed(diff) < $signed({{(TIME_W + 1 - WIN_W){1'b0}}, window_reg});
    assign gt_w = $signed(diff) > $signed({{(TIME_W + 1 - WIN_W){1'b0}}, window_reg});

    // Last hit reached by the window, never behind the current center.
    always_comb
    begin
        mx_dec = (mx_reg == '0) ? '0 : mx_reg - CNT_W'(1);
        if (mx_dec < idx_reg)
        begin
            mx_dec = idx_reg;
        end
    end

    // cnt = mx - mn + 1 > thr, rearranged to avoid a subtraction.
    assign cnt_lhs = {1'b0, mx_dec} + (CNT_W + 1)'(1);
    assign cnt_rhs = {1'b0, thr_reg} + {1'b0, mn_reg};
    assign over    = cnt_lhs > cnt_rhs;

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        thr_next       = thr_reg;
        hit_total_next = hit_total_reg;
        run_done_next  = run_done_reg;
        ev_cnt_next    = ev_cnt_reg;
        asg_tot_next   = asg_tot_reg;
        ctr_next       = ctr_reg;
        idx_next       = idx_reg;
        mn_next        = mn_reg;
        mx_next        = mx_reg;
        a_next         = a_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mark_lbl_next  = mark_lbl_reg;
        ec_next        = ec_reg;
        in_ev_next     = in_ev_reg;
        t0_next        = t0_reg;
        tidx_next      = tidx_reg;
        base_next      = base_reg;
        last_next      = last_reg;
        have_last_next = have_last_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        assigned_next  = assigned_reg;
        evn_next       = evn_reg;
        rel_next       = rel_reg;

        t_we    = 1'b0;
        t_addr  = '0;
        t_wdata = hit_time;
        l_we    = 1'b0;
        l_addr  = '0;
        l_wdata = '0;
        r_we    = 1'b0;
        r_addr  = '0;
        r_wdata = diff[TIME_W-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_WINDOW)
            begin
                window_next = cfg_data;
            end
            else
            begin
                thr_next = cfg_data[THR_W-1:0];
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                l_addr = hit_index;
                r_addr = hit_index;
                if (accept)
                begin
                    status_next   = ST_OK;
                    assigned_next = 1'b0;
                    evn_next      = '0;
                    rel_next      = '0;
                    unique case (cmd_t'(cmd))
                        CMD_LOAD:
                        begin
                            out_valid_next = 1'b1;
                            if (hit_total_reg < CNT_W'(MAX_HITS))
                            begin
                                t_we           = 1'b1;
                                t_addr         = hit_total_reg[ADDR_W-1:0];
                                hit_total_next = hit_total_reg + CNT_W'(1);
                                run_done_next  = 1'b0;
                                ev_cnt_next    = '0;
                                asg_tot_next   = '0;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        CMD_RUN:
                        begin
                            ctr_next   = '0;
                            ec_next    = '0;
                            in_ev_next = 1'b0;
                            mn_next    = '0;
                            idx_next   = '0;
                            mx_next    = CNT_W'(1);
                            state_next = S_CLR;
                        end
                        CMD_READ:
                        begin
                            if (!run_done_reg)
                            begin
                                status_next    = ST_NOT_RUN;
                                out_valid_next = 1'b1;
                            end
                            else if ({1'b0, hit_index} >= hit_total_reg)
                            begin
                                status_next    = ST_RANGE;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_RD_WAIT;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            out_valid_next = 1'b1;
                            hit_total_next = '0;
                            run_done_next  = 1'b0;
                            ev_cnt_next    = '0;
                            asg_tot_next   = '0;
                        end
                    endcase
                end
            end
            S_RD_WAIT:
            begin
                out_valid_next = 1'b1;
                assigned_next  = l_rdata[LMEM_W-1];
                evn_next       = l_rdata[LMEM_W-1] ? l_rdata[EVNUM_W-1:0] : '0;
                rel_next       = l_rdata[LMEM_W-1] ? r_rdata : '0;
                state_next     = S_IDLE;
            end
            S_CLR:
            begin
                if (ctr_reg < hit_total_reg)
                begin
                    l_we     = 1'b1;
                    l_addr   = ctr_reg[ADDR_W-1:0];
                    ctr_next = ctr_reg + CNT_W'(1);
                end
                else if (hit_total_reg == '0)
                begin
                    ctr_next       = '0;
                    have_last_next = 1'b0;
                    total_next     = '0;
                    state_next     = S_REL_RD;
                end
                else
                begin
                    state_next = S_T0_RD;
                end
            end
            S_T0_RD:
            begin
                t_addr     = '0;
                state_next = S_T0_WT;
            end
            S_T0_WT:
            begin
                t0_next    = t_rdata;
                state_next = S_INIT_RD;
            end
            S_INIT_RD:
            begin
                t_addr = mx_reg[ADDR_W-1:0];
                if (mx_reg < hit_total_reg)
                begin
                    state_next = S_INIT_WT;
                end
                else
                begin
                    state_next = S_INIT_DEC;
                end
            end
            S_INIT_WT:
            begin
                if (lt_w)
                begin
                    mx_next    = mx_reg + CNT_W'(1);
                    state_next = S_INIT_RD;
                end
                else
                begin
                    state_next = S_INIT_DEC;
                end
            end
            S_INIT_DEC:
            begin
                // A first window over threshold becomes event 0.
                if (mx_reg > thr_reg)
                begin
                    lo_next       = '0;
                    hi_next       = mx_reg;
                    mark_lbl_next = '0;
                    in_ev_next    = 1'b1;
                    state_next    = S_MARK;
                end
                else
                begin
                    state_next = S_IDX_RD;
                end
            end
            S_IDX_RD:
            begin
                t_addr = idx_reg[ADDR_W-1:0];
                if (idx_reg < hit_total_reg)
                begin
                    state_next = S_IDX_WT;
                end
                else
                begin
                    ctr_next       = '0;
                    have_last_next = 1'b0;
                    total_next     = '0;
                    state_next     = S_REL_RD;
                end
            end
            S_IDX_WT:
            begin
                tidx_next  = t_rdata;
                state_next = S_MN_RD;
            end
            S_MN_RD:
            begin
                t_addr = mn_reg[ADDR_W-1:0];
                if (mn_reg < idx_reg)
                begin
                    state_next = S_MN_WT;
                end
                else
                begin
                    a_next     = mx_reg;
                    state_next = S_MX_RD;
                end
            end
            S_MN_WT:
            begin
                if (gt_w)
                begin
                    mn_next    = mn_reg + CNT_W'(1);
                    state_next = S_MN_RD;
                end
                else
                begin
                    a_next     = mx_reg;
                    state_next = S_MX_RD;
                end
            end
            S_MX_RD:
            begin
                t_addr = mx_reg[ADDR_W-1:0];
                if (mx_reg < hit_total_reg)
                begin
                    state_next = S_MX_WT;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_MX_WT:
            begin
                if (lt_w)
                begin
                    mx_next    = mx_reg + CNT_W'(1);
                    state_next = S_MX_RD;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // mx_reg here is the exclusive end of the hits just reached.
                mx_next  = mx_dec;
                idx_next = (mx_dec > idx_reg) ? mx_dec : idx_reg + CNT_W'(1);
                lo_next  = a_reg;
                hi_next  = mx_reg;
                mark_lbl_next = ec_reg;
                state_next    = in_ev_reg ? S_MARK : S_IDX_RD;
                if (over)
                begin
                    if (!in_ev_reg)
                    begin
                        in_ev_next    = 1'b1;
                        ec_next       = ec_reg + LABEL_W'(1);
                        lo_next       = mn_reg;
                        hi_next       = mx_dec + CNT_W'(1);
                        mark_lbl_next = ec_reg + LABEL_W'(1);
                        state_next    = S_MARK;
                    end
                end
                else
                begin
                    in_ev_next = 1'b0;
                end
            end
            S_MARK:
            begin
                if (lo_reg < hi_reg)
                begin
                    l_we    = 1'b1;
                    l_addr  = lo_reg[ADDR_W-1:0];
                    l_wdata = {1'b1, mark_lbl_reg};
                    lo_next = lo_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_IDX_RD;
                end
            end
            S_REL_RD:
            begin
                t_addr = ctr_reg[ADDR_W-1:0];
                l_addr = ctr_reg[ADDR_W-1:0];
                if (ctr_reg < hit_total_reg)
                begin
                    state_next = S_REL_WT;
                end
                else
                begin
                    ev_cnt_next    = ec_reg;
                    asg_tot_next   = total_reg;
                    run_done_next  = 1'b1;
                    status_next    = ST_OK;
                    assigned_next  = 1'b0;
                    evn_next       = '0;
                    rel_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_REL_WT:
            begin
                if (l_rdata[LMEM_W-1])
                begin
                    r_we           = 1'b1;
                    r_addr         = ctr_reg[ADDR_W-1:0];
                    base_next      = base_sel;
                    last_next      = l_rdata[LABEL_W-1:0];
                    have_last_next = 1'b1;
                    total_next     = total_reg + CNT_W'(1);
                end
                ctr_next   = ctr_reg + CNT_W'(1);
                state_next = S_REL_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            window_reg    <= WIN_W'(3600);
            thr_reg       <= THR_W'(400);
            hit_total_reg <= '0;
            run_done_reg  <= 1'b0;
            ev_cnt_reg    <= '0;
            asg_tot_reg   <= '0;
            out_valid_reg <= 1'b0;
            in_ev_reg     <= 1'b0;
            have_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            thr_reg       <= thr_next;
            hit_total_reg <= hit_total_next;
            run_done_reg  <= run_done_next;
            ev_cnt_reg    <= ev_cnt_next;
            asg_tot_reg   <= asg_tot_next;
            out_valid_reg <= out_valid_next;
            in_ev_reg     <= in_ev_next;
            have_last_reg <= have_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctr_reg      <= ctr_next;
        idx_reg      <= idx_next;
        mn_reg       <= mn_next;
        mx_reg       <= mx_next;
        a_reg        <= a_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mark_lbl_reg <= mark_lbl_next;
        ec_reg       <= ec_next;
        t0_reg       <= t0_next;
        tidx_reg     <= tidx_next;
        base_reg     <= base_next;
        last_reg     <= last_next;
        total_reg    <= total_next;
        status_reg   <= status_next;
        assigned_reg <= assigned_next;
        evn_reg      <= evn_next;
        rel_reg      <= rel_next;
    end

endmodule

[rtl/core/hwe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwe_checker: port-level checks for the hit window event builder
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
module hwe_checker
    import hwe_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [1:0]           status,
    input logic                 assigned,
    input logic [EVNUM_W-1:0]   event_number,
    input logic [TIME_W-1:0]    relative_time,
    input logic [CNT_W-1:0]     hits_assigned
);

    // Every accepted transaction keeps the block busy until its result goes out.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an accepted transaction");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_assigned_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && assigned |-> status == ST_OK && hits_assigned != '0)
        else $error("assigned hit reported with bad status or empty count");

    a_unassigned_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !assigned |-> event_number == '0 && relative_time == '0)
        else $error("label fields not zero for an unassigned result");

endmodule

bind hit_window_event_builder hwe_checker u_hwe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .assigned      (assigned),
    .event_number  (event_number),
    .relative_time (relative_time),
    .hits_assigned (hits_assigned)
);

[tb/hit_window_event_builder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hit_window_event_builder_tb: self-checking bench for the event builder
// Directed tests cover the command set, the status codes and the store
// limits. Random sessions then clear the store, load time-ordered hit bursts
// (plus some unordered noise), run the grouping and read the hits back. Each
// result is checked field by field against a behavioral predictor.
// ----------------------------------------------------------------------------
module hit_window_event_builder_tb;
    import hwe_pkg::*;

    // One expected result transaction.
    typedef struct {
        logic [1:0]          status;
        logic                assigned;
        logic [EVNUM_W-1:0]  event_number;
        logic [TIME_W-1:0]   relative_time;
        logic [CNT_W-1:0]    events_found;
        logic [CNT_W-1:0]    hits_assigned;
    } hit_answer_t;

    // A row of the directed table. Rows with has_status carry a typed
    // status and expect both counters at zero.
    typedef struct {
        cmd_t                op;
        logic [TIME_W-1:0]   stamp;
        logic [ADDR_W-1:0]   index;
        bit                  has_status;
        status_t             status;
    } table_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [1:0]          cmd;
    logic [TIME_W-1:0]   hit_time;
    logic [ADDR_W-1:0]   hit_index;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          status;
    logic                assigned;
    logic [EVNUM_W-1:0]  event_number;
    logic [TIME_W-1:0]   relative_time;
    logic [CNT_W-1:0]    events_found;
    logic [CNT_W-1:0]    hits_assigned;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [WIN_W-1:0]    cfg_data;

    hit_window_event_builder dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .hit_time(hit_time), .hit_index(hit_index),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .assigned(assigned), .event_number(event_number),
        .relative_time(relative_time), .events_found(events_found),
        .hits_assigned(hits_assigned),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the hit store, the labels and the
    // counters, plus the two configuration registers.
    // ------------------------------------------------------------------------
    logic [TIME_W-1:0]   stamp_mem [MAX_HITS];
    int                  label_mem [MAX_HITS];
    bit                  labeled   [MAX_HITS];
    logic [TIME_W-1:0]   offset_mem[MAX_HITS];
    int                  stored_hits;
    bit                  grouped;
    int                  event_count;
    int                  labeled_count;
    int                  half_window;
    int                  trigger_level;

    hit_answer_t         pending_answers[$];
    int                  errors;
    int                  items_sent;
    int                  hold_request;

    // Signed time difference of two stored hits.
    function automatic longint stamp_gap(int a, int b);
        return longint'({16'd0, stamp_mem[a]}) - longint'({16'd0, stamp_mem[b]});
    endfunction

    function automatic void label_range(int lo, int hi, int lab);
        for (int i = lo; i < hi; i++)
        begin
            label_mem[i] = lab;
            labeled[i] = 1'b1;
        end
    endfunction

    // The grouping pass. The first window is anchored at hit 0; after that
    // the window center jumps to the last hit the previous window reached.
    // An open event absorbs every newly reached hit until a window falls
    // to or below the trigger level.
    function automatic void group_hits();
        int                 n;
        longint             w;
        int                 lo;
        int                 hi;
        int                 center;
        int                 reach_lo;
        int                 reach_hi;
        int                 count;
        int                 step_to;
        int                 ev;
        int                 total;
        int                 prev_label;
        bit                 open_event;
        bit                 seen_label;
        logic [TIME_W-1:0]  base;

        n = stored_hits;
        w = half_window;
        lo = 0;
        hi = 1;
        center = 0;
        ev = 0;
        total = 0;
        prev_label = 0;
        open_event = 1'b0;
        seen_label = 1'b0;
        base = '0;
        for (int i = 0; i < n; i++)
            labeled[i] = 1'b0;
        if (n > 0)
        begin
            while (hi < n && stamp_gap(hi, 0) < w)
                hi++;
            // An over-threshold first window is event zero.
            if (hi > trigger_level)
            begin
                label_range(0, hi, 0);
                open_event = 1'b1;
            end
            while (center < n)
            begin
                while (lo < center && stamp_gap(center, lo) > w)
                    lo++;
                if (hi < 0)
                    hi = 0;
                reach_lo = hi;
                while (hi < n && stamp_gap(hi, center) < w)
                    hi++;
                reach_hi = hi;
                hi -= 1;
                if (hi < center)
                    hi = center;
                count = hi - lo + 1;
                step_to = (hi > center) ? hi : center + 1;
                if (count > trigger_level)
                begin
                    if (open_event)
                        label_range(reach_lo, reach_hi, ev);
                    else
                    begin
                        open_event = 1'b1;
                        ev++;
                        label_range(lo, hi + 1, ev);
                    end
                end
                else
                begin
                    if (open_event)
                        label_range(reach_lo, reach_hi, ev);
                    open_event = 1'b0;
                end
                center = step_to;
            end
        end
        // Relative times restart at every change of label in store order.
        for (int i = 0; i < n; i++)
        begin
            offset_mem[i] = '0;
            if (labeled[i])
            begin
                if (!seen_label || prev_label != label_mem[i])
                    base = stamp_mem[i];
                seen_label = 1'b1;
                prev_label = label_mem[i];
                offset_mem[i] = stamp_mem[i] - base;
                total++;
            end
        end
        event_count = ev;
        labeled_count = total;
        grouped = 1'b1;
    endfunction

    // Applies one accepted command to the predictor and returns its answer.
    function automatic hit_answer_t predict_answer(cmd_t op, logic [TIME_W-1:0] stamp,
                                                   logic [ADDR_W-1:0] index);
        hit_answer_t ans;
        ans = '{ST_OK, 1'b0, '0, '0, '0, '0};
        case (op)
            CMD_LOAD:
                if (stored_hits < MAX_HITS)
                begin
                    stamp_mem[stored_hits] = stamp;
                    stored_hits++;
                    grouped = 1'b0;
                    event_count = 0;
                    labeled_count = 0;
                end
                else
                    ans.status = ST_FULL;
            CMD_RUN:
                group_hits();
            CMD_READ:
                if (!grouped)
                    ans.status = ST_NOT_RUN;
                else if (int'(index) >= stored_hits)
                    ans.status = ST_RANGE;
                else if (labeled[index])
                begin
                    ans.assigned = 1'b1;
                    ans.event_number = label_mem[index][EVNUM_W-1:0];
                    ans.relative_time = offset_mem[index];
                end
            default:
            begin
                stored_hits = 0;
                grouped = 1'b0;
                event_count = 0;
                labeled_count = 0;
            end
        endcase
        ans.events_found = event_count[CNT_W-1:0];
        ans.hits_assigned = labeled_count[CNT_W-1:0];
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. A transaction is offered at a rising edge and held until
    // the block takes it; the prediction is made at the accepting edge.
    // With has_typed set, the answer is typed_status with all other fields zero.
    // ------------------------------------------------------------------------
    task automatic send_command(cmd_t op, logic [TIME_W-1:0] stamp,
                                logic [ADDR_W-1:0] index,
                                bit has_typed = 1'b0, status_t typed_status = ST_OK);
        hit_answer_t ans;
        in_valid <= 1'b1;
        cmd <= op;
        hit_time <= stamp;
        hit_index <= index;
        do
            @(posedge clk);
        while (in_stall);
        ans = predict_answer(op, stamp, index);
        if (has_typed)
            ans = '{typed_status, 1'b0, '0, '0, '0, '0};
        pending_answers = {pending_answers, ans};
        items_sent++;
    endtask

    // Burst-shaped idling between transactions.
    int burst_left = 0;
    task automatic sender_gap();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic issue(cmd_t op, logic [TIME_W-1:0] stamp, logic [ADDR_W-1:0] index);
        send_command(op, stamp, index);
        sender_gap();
    endtask

    // Registers are only written once the block has answered everything.
    task automatic write_register(logic which, logic [WIN_W-1:0] value);
        in_valid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (which == CFG_WINDOW)
            half_window = int'(value);
        else
            trigger_level = int'(value[THR_W-1:0]);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: a tick counter redraws among four stall modes, with one long
    // hold-off on request so that the block fills up and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_seen;
        int mode;
        int tick;
        hold_seen = 0;
        mode = 0;
        tick = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != hold_seen)
            begin
                hold_seen = hold_request;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                tick++;
                if (tick % 64 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ((tick % 8) < 3);
                endcase
            end
        end
    end

    // Result checker: compares each taken result with the oldest expectation.
    always @(posedge clk)
    begin
        hit_answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result transaction, status %0d", $time, status);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                    errors++;
                end
                if (assigned !== want.assigned)
                begin
                    $display("%0t: assigned expected %0d actual %0d",
                             $time, want.assigned, assigned);
                    errors++;
                end
                if (event_number !== want.event_number)
                begin
                    $display("%0t: event_number expected %0d actual %0d",
                             $time, want.event_number, event_number);
                    errors++;
                end
                if (relative_time !== want.relative_time)
                begin
                    $display("%0t: relative_time expected %0h actual %0h",
                             $time, want.relative_time, relative_time);
                    errors++;
                end
                if (events_found !== want.events_found)
                begin
                    $display("%0t: events_found expected %0d actual %0d",
                             $time, want.events_found, events_found);
                    errors++;
                end
                if (hits_assigned !== want.hits_assigned)
                begin
                    $display("%0t: hits_assigned expected %0d actual %0d",
                             $time, want.hits_assigned, hits_assigned);
                    errors++;
                end
            end
        end
    end

    // Hard limit on simulated time.
    initial
    begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Directed table: status codes, empty store, the time extremes, reads out
    // of range, unordered times and a load that invalidates a finished run.
    // ------------------------------------------------------------------------
    localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};
    table_row_t directed [] = '{
        '{CMD_READ,  48'd0,   12'd0,    1'b1, ST_NOT_RUN},
        '{CMD_RUN,   48'd0,   12'd0,    1'b1, ST_OK},
        '{CMD_READ,  48'd0,   12'd0,    1'b1, ST_RANGE},
        '{CMD_LOAD,  48'd0,   12'd0,    1'b1, ST_OK},
        '{CMD_LOAD,  T_MAX,   12'd0,    1'b1, ST_OK},
        '{CMD_READ,  48'd0,   12'd1,    1'b1, ST_NOT_RUN},
        '{CMD_RUN,   48'd0,   12'd0,    1'b0, ST_OK},
        '{CMD_READ,  48'd0,   12'd0,    1'b0, ST_OK},
        '{CMD_READ,  48'd0,   12'd1,    1'b0, ST_OK},
        '{CMD_READ,  48'd0,   12'hFFF,  1'b0, ST_OK},
        '{CMD_CLEAR, T_MAX,   12'hFFF,  1'b1, ST_OK},
        '{CMD_READ,  48'd0,   12'd0,    1'b1, ST_NOT_RUN},
        '{CMD_LOAD,  48'd500, 12'd0,    1'b1, ST_OK},
        '{CMD_LOAD,  48'd100, 12'd0,    1'b1, ST_OK},
        '{CMD_LOAD,  48'd2000,12'd0,    1'b1, ST_OK},
        '{CMD_RUN,   48'd0,   12'd0,    1'b0, ST_OK},
        '{CMD_READ,  48'd0,   12'd0,    1'b0, ST_OK},
        '{CMD_READ,  48'd0,   12'd2,    1'b0, ST_OK},
        '{CMD_READ,  48'd0,   12'd3,    1'b0, ST_OK},
        '{CMD_LOAD,  48'd2100,12'd0,    1'b1, ST_OK},
        '{CMD_READ,  48'd0,   12'd0,    1'b1, ST_NOT_RUN},
        '{CMD_CLEAR, 48'd0,   12'd0,    1'b1, ST_OK}
    };

    // One random session: clear, load a burst, run, read back.
    task automatic run_session();
        int                 n;
        logic [TIME_W-1:0]  t;
        int                 spread;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 40);
        spread = (half_window > 8) ? half_window / 2 : 8;
        t = TIME_W'({$urandom, $urandom});
        issue(CMD_CLEAR, TIME_W'({$urandom, $urandom}), ADDR_W'($urandom));
        if ($urandom_range(0, 3) == 0)
            issue(CMD_READ, '0, ADDR_W'($urandom));
        for (int i = 0; i < n; i++)
        begin
            // Mostly ordered hits; now and then a big jump or a random stamp.
            case ($urandom_range(0, 19))
                0: t = TIME_W'({$urandom, $urandom});
                1: t = t + TIME_W'({$urandom, 8'd0});
                default: t = t + TIME_W'($urandom_range(0, spread));
            endcase
            issue(CMD_LOAD, t, ADDR_W'($urandom));
        end
        issue(CMD_RUN, TIME_W'({$urandom, $urandom}), ADDR_W'($urandom));
        if ($urandom_range(0, 4) == 0)
            issue(CMD_RUN, '0, '0);
        for (int i = 0; i < n + 2; i++)
            issue(CMD_READ, '0, ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom)
                                                           : ADDR_W'($urandom_range(0, n)));
        if ($urandom_range(0, 5) == 0)
        begin
            issue(CMD_LOAD, TIME_W'({$urandom, $urandom}), ADDR_W'($urandom));
            issue(CMD_READ, '0, '0);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_LOAD;
        hit_time = '0;
        hit_index = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WINDOW;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        hold_request = 0;
        stored_hits = 0;
        grouped = 1'b0;
        event_count = 0;
        labeled_count = 0;
        half_window = 3600;
        trigger_level = 400;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[r])
        begin
            send_command(directed[r].op, directed[r].stamp, directed[r].index,
                         directed[r].has_status, directed[r].status);
            sender_gap();
        end

        // Fill the store to its depth, push one load past it, run and read
        // the ends. The receiver holds off for a long stretch meanwhile.
        write_register(CFG_WINDOW, 20'd40);
        write_register(CFG_THRESHOLD, 20'd6);
        issue(CMD_CLEAR, '0, '0);
        hold_request++;
        for (int i = 0; i < MAX_HITS; i++)
            send_command(CMD_LOAD, 48'(i * 8 + ((i / 300) % 2) * 4000 * i), '0);
        send_command(CMD_LOAD, T_MAX, '0, 1'b1, ST_FULL);
        issue(CMD_RUN, '0, '0);
        issue(CMD_READ, '0, 12'd0);
        issue(CMD_READ, '0, 12'd2048);
        issue(CMD_READ, '0, 12'hFFF);

        // Random sessions; the first few sweep the register extremes.
        for (int s = 0; items_sent < 2000 + MAX_HITS + 40; s++)
        begin
            if (s < 4 || $urandom_range(0, 3) == 0)
            begin
                case (s)
                    0: begin write_register(CFG_WINDOW, 20'd0);
                             write_register(CFG_THRESHOLD, 20'd0); end
                    1: begin write_register(CFG_WINDOW, 20'hFFFFF);
                             write_register(CFG_THRESHOLD, 20'd4096); end
                    2: begin write_register(CFG_WINDOW, 20'hFFFFF);
                             write_register(CFG_THRESHOLD, 20'd0); end
                    3: begin write_register(CFG_WINDOW, 20'd1);
                             write_register(CFG_THRESHOLD, 20'd8191); end
                    default:
                    begin
                        write_register(CFG_WINDOW, $urandom_range(0, 3) == 0 ?
                                       WIN_W'($urandom) : WIN_W'($urandom_range(0, 400)));
                        write_register(CFG_THRESHOLD, $urandom_range(0, 4) == 0 ?
                                       WIN_W'($urandom) : WIN_W'($urandom_range(0, 8)));
                    end
                endcase
            end
            run_session();
        end

        in_valid <= 1'b0;
        wait (pending_answers.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
